// ----- src/assert_macros.svh -----
// assertion macros used by the lifo store back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define LWS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lifo store check failed");

// next-cycle implication, masked during reset
`define LWS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lifo store check failed");

`endif

// ----- src/lws_pkg.sv -----
// types and constants of the lifo store with search
`default_nettype none

package lws_pkg;

   // store depth and derived widths
   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(DEPTH);

   // raw action codes on the request channel
   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;
   localparam logic [1:0] ACT_DUMP   = 2'd3;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_SEARCH,
      OP_DUMP
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SEARCH,
      S_DUMP
   } state_type;

   // classified request as held in the queue
   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
   } req_item_type;

endpackage

`default_nettype wire

// ----- src/lws_ifs.sv -----
// request and response channel interfaces
`default_nettype none

interface lws_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

interface lws_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [31:0] data;
   logic               last;

   modport source (output valid, status, data, last, input ready);
   modport sink   (input valid, status, data, last, output ready);
endinterface

`default_nettype wire

// ----- src/lifo_store_with_search.sv -----
// top level of the lifo store with search
//
//   channel    dir   handshake              payload
//   req_chan   in    valid / ready          action[1:0], value[31:0] signed
//   rsp_chan   out   valid / ready          status[2:0], data[31:0] signed, last
//
// push is done in idle, pop via the pop state (in idle when empty); search and
// dump read one entry per cycle via the memory read port (dump when not stalled).
// a two-entry request queue sits before the sequencer and a response
// register after it, so requests are taken while a response waits.
// reset is synchronous and empties the store and the queue at once.
// a stalled response holds the sequencer; a full queue holds off requests.
`default_nettype none

module lifo_store_with_search
   import lws_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   lws_req_if.sink   req_chan,
   lws_rsp_if.source rsp_chan
);

   logic         q_valid;
   logic         q_ready;
   req_item_type q_item;

   // request intake and decode
   lws_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item)
   );

   // stack execution and responses
   lws_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_item   (q_item),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ----- src/lws_front.sv -----
// front end: accepts requests, decodes the action and queues them
`default_nettype none

module lws_front
   import lws_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   lws_req_if.sink     req_chan,
   output logic        q_valid,
   input  wire logic   q_ready,
   output req_item_type q_item
);

   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   req_item_type buf_ff [2];
   req_item_type dec_item;
   logic         push, pop;

   // action decode
   always_comb begin
      dec_item.value = req_chan.value;
      case (req_chan.action)
         ACT_PUSH:   dec_item.op = OP_PUSH;
         ACT_POP:    dec_item.op = OP_POP;
         ACT_SEARCH: dec_item.op = OP_SEARCH;
         ACT_DUMP:   dec_item.op = OP_DUMP;
         default:    dec_item.op = OP_DUMP;
      endcase
   end

   // two-entry queue handshake
   assign req_chan.ready = (count_ff != 2'd2);
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = (count_ff != 2'd0);
   assign pop     = q_valid && q_ready;
   assign q_item  = buf_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= dec_item;
      end
   end

endmodule

`default_nettype wire

// ----- src/lws_back.sv -----
// back end: stack memory, sequencer and response register
`default_nettype none

`include "assert_macros.svh"

module lws_back
   import lws_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   output logic         q_ready,
   input  req_item_type q_item,
   lws_rsp_if.source    rsp_chan
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               hit_ff, hit_in;
   logic signed [31:0] key_ff, key_in;
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_data_ff;
   logic               rsp_last_ff;

   logic               slot_free;
   logic               emit;
   status_type         emit_status;
   logic signed [31:0] emit_data;
   logic               emit_last;
   logic               wr_en;
   logic [CNT_W-1:0]   fill_dec;
   logic [IDX_W-1:0]   top_idx;
   logic               is_empty, is_full, hit_now;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign fill_dec  = fill_ff - CNT_W'(1);
   assign top_idx   = fill_dec[IDX_W-1:0];
   assign is_empty  = (fill_ff == '0);
   assign is_full   = (fill_ff == FILL_FULL);
   assign hit_now   = hit_ff || (rd_data_ff == key_ff);

   // sequencer next state and result selection
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      key_in      = key_ff;
      q_ready     = 1'b0;
      emit        = 1'b0;
      emit_status = ST_OK;
      emit_data   = '0;
      emit_last   = 1'b1;
      wr_en       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && slot_free) begin
               q_ready = 1'b1;
               case (q_item.op)
                  OP_PUSH: begin
                     emit = 1'b1;
                     if (is_full) begin
                        emit_status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        emit_status = ST_EMPTY;
                     end else begin
                        fill_in  = fill_dec;
                        idx_in   = top_idx;
                        state_in = S_POP;
                     end
                  end
                  OP_SEARCH: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        emit_status = ST_EMPTY;
                     end else begin
                        key_in   = q_item.value;
                        hit_in   = 1'b0;
                        idx_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        emit        = 1'b1;
                        emit_status = ST_EMPTY;
                     end else begin
                        idx_in   = top_idx;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     q_ready = 1'b0;
                  end
               endcase
            end
         end
         S_POP: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_data = rd_data_ff;
               state_in  = S_IDLE;
            end
         end
         S_SEARCH: begin
            // one entry compared per cycle, bottom to top
            if (idx_ff == top_idx) begin
               if (slot_free) begin
                  emit        = 1'b1;
                  emit_status = hit_now ? ST_FOUND : ST_NOT_FOUND;
                  state_in    = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
               hit_in = hit_now;
            end
         end
         S_DUMP: begin
            // one entry streamed per cycle while the response slot is free, top to bottom
            if (slot_free) begin
               emit      = 1'b1;
               emit_data = rd_data_ff;
               emit_last = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      key_ff <= key_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_data_ff   <= emit_data;
         rsp_last_ff   <= emit_last;
      end
   end

   // stack memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[IDX_W-1:0]] <= q_item.value;
      end
      rd_data_ff <= mem[idx_in];
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // checks
   `LWS_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_FULL)
   `LWS_ASSERT_IMP(a_scan_nonempty, clock, reset,
      state_ff == S_SEARCH || state_ff == S_DUMP, !is_empty && CNT_W'(idx_ff) < fill_ff)
   `LWS_ASSERT_NXT(a_push_grows, clock, reset, q_ready && q_item.op == OP_PUSH && !is_full,
      fill_ff == $past(fill_ff) + CNT_W'(1))
   `LWS_ASSERT_IMP(a_take_idle, clock, reset, q_ready, state_ff == S_IDLE && slot_free)

endmodule

`default_nettype wire

// ----- test/tb_lifo_store_with_search.sv -----
// self-checking testbench of the lifo store with search
`timescale 1ns / 100ps

module tb_lifo_store_with_search;
   import lws_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int RSP_HOLD    = 300;
   localparam int ITEM_TARGET = 460;

   typedef struct {
      logic [1:0]         action;
      logic signed [31:0] value;
   } lifo_req_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] data;
      logic               last;
   } lifo_rsp_type;

   logic clock;
   logic reset;

   lws_req_if req_bus ();
   lws_rsp_if rsp_bus ();

   lifo_store_with_search uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // requests waiting for the driver and responses owed by the block
   lifo_req_type queued_requests [$];
   lifo_rsp_type owed_responses [$];

   // image of the store as the block should hold it
   logic signed [31:0] stack_image [DEPTH];
   int                 image_fill;

   int           error_count;
   int           request_count;
   logic         req_fired;
   logic         rsp_fired;
   bit           req_idle_on;
   bit           rsp_idle_on;
   int           req_gap;
   int           rsp_gap;
   int           hold_left;
   int           stall_ticket;
   int           stall_served;
   lifo_req_type next_req;
   logic signed [31:0] value_pool [8];

   // clock and known values on every input from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_PUSH;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // gap length, mostly short with a few long ones
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // work out the responses of one accepted request
   task automatic apply_to_stack_image(input logic [1:0] action,
                                       input logic signed [31:0] value);
      lifo_rsp_type rsp;
      bit           hit;
      rsp.status = ST_OK;
      rsp.data   = '0;
      rsp.last   = 1'b1;
      hit        = 1'b0;
      case (action)
         ACT_PUSH: begin
            if (image_fill >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               stack_image[image_fill] = value;
               image_fill++;
            end
            owed_responses.push_back(rsp);
         end
         ACT_POP: begin
            if (image_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               image_fill--;
               rsp.data = stack_image[image_fill];
            end
            owed_responses.push_back(rsp);
         end
         ACT_SEARCH: begin
            if (image_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < image_fill; i++)
                  if (stack_image[i] === value) hit = 1'b1;
               rsp.status = hit ? ST_FOUND : ST_NOT_FOUND;
            end
            owed_responses.push_back(rsp);
         end
         default: begin
            if (image_fill == 0) begin
               rsp.status = ST_EMPTY;
               owed_responses.push_back(rsp);
            end else begin
               // top to bottom, last only on the bottom entry
               for (int i = image_fill - 1; i >= 0; i--) begin
                  rsp.data = stack_image[i];
                  rsp.last = (i == 0);
                  owed_responses.push_back(rsp);
               end
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
   endtask

   // request driver, changes at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (queued_requests.size() > 0) begin
            next_req = queued_requests.pop_front();
            req_bus.action <= next_req.action;
            req_bus.value  <= next_req.value;
            req_bus.valid  <= 1'b1;
            req_gap = req_idle_on ? draw_gap() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response ready, with random gaps and a counted long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
         rsp_gap = 0;
         stall_served = stall_ticket;
      end else if (stall_served != stall_ticket) begin
         stall_served = stall_ticket;
         hold_left = RSP_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!rsp_idle_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_fired) begin
         rsp_gap = draw_gap();
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: check responses, then predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         rsp_fired <= rsp_bus.valid && rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (owed_responses.size() == 0) begin
               error_count++;
               $display({"%0t: unexpected response, expected none ",
                         "actual status %0d data %h last %b"},
                        $time, rsp_bus.status, rsp_bus.data, rsp_bus.last);
            end else begin
               if (rsp_bus.status !== owed_responses[0].status)
                  report_mismatch("status", 32'(owed_responses[0].status), 32'(rsp_bus.status));
               if (rsp_bus.data !== owed_responses[0].data)
                  report_mismatch("data", owed_responses[0].data, rsp_bus.data);
               if (rsp_bus.last !== owed_responses[0].last)
                  report_mismatch("last", 32'(owed_responses[0].last), 32'(rsp_bus.last));
               void'(owed_responses.pop_front());
            end
         end
         if (req_bus.valid && req_bus.ready)
            apply_to_stack_image(req_bus.action, req_bus.value);
      end
   end

   task automatic add_request(input logic [1:0] action, input logic signed [31:0] value);
      lifo_req_type req;
      req.action = action;
      req.value  = value;
      queued_requests.push_back(req);
      request_count++;
   endtask

   // sender pause: everything sent and every response back
   task automatic wait_until_drained();
      while (queued_requests.size() != 0 || req_bus.valid || owed_responses.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value(input int pool_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < pool_pct) return value_pool[$urandom_range(0, 7)];
      if (r < 90) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0;
         default: return -32'sd1;
      endcase
   endfunction

   // fill to full, overflow, search, dump and drain again
   task automatic run_fill_drain(input bit with_hold);
      logic signed [31:0] v;
      logic signed [31:0] kept;
      int n;
      kept = '0;
      n = DEPTH - image_fill + 3;
      if (with_hold) stall_ticket++;
      for (int i = 0; i < n; i++) begin
         // even values only, so an odd search key is absent
         v = $urandom & ~32'sd1;
         if (i == n / 2) kept = v;
         add_request(ACT_PUSH, v);
      end
      add_request(ACT_SEARCH, kept);
      add_request(ACT_SEARCH, kept | 32'sd1);
      add_request(ACT_DUMP, $urandom);
      for (int i = 0; i < DEPTH + 2; i++)
         add_request(ACT_POP, $urandom);
   endtask

   // stimulus
   initial begin
      int phase;
      int len;
      int r;
      error_count   = 0;
      request_count = 0;
      image_fill    = 0;
      stall_ticket  = 0;
      req_gap       = 0;
      req_idle_on   = 1'b0;
      rsp_idle_on   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, field extremes, hits and misses
      add_request(ACT_POP, 32'sh0000_0063);
      add_request(ACT_SEARCH, 32'sh0);
      add_request(ACT_DUMP, 32'sh0000_0005);
      add_request(ACT_PUSH, 32'sh8000_0000);
      add_request(ACT_PUSH, 32'sh7FFF_FFFF);
      add_request(ACT_PUSH, 32'sh0);
      add_request(ACT_PUSH, -32'sd1);
      add_request(ACT_PUSH, 32'sh5555_5555);
      add_request(ACT_PUSH, 32'shAAAA_AAAA);
      add_request(ACT_SEARCH, 32'sh8000_0000);
      add_request(ACT_SEARCH, 32'sh5555_5555);
      add_request(ACT_SEARCH, 32'sh0000_0001);
      add_request(ACT_SEARCH, 32'sh7FFF_FFFE);
      add_request(ACT_DUMP, 32'sh0);
      add_request(ACT_POP, 32'sh1234_5678);
      add_request(ACT_POP, -32'sd1);
      add_request(ACT_SEARCH, 32'sh5555_5555);
      add_request(ACT_DUMP, 32'shFFFF_0000);
      repeat (4) add_request(ACT_POP, 32'sh0);
      add_request(ACT_POP, 32'sh0);
      add_request(ACT_SEARCH, -32'sd1);
      add_request(ACT_DUMP, 32'sh0);
      wait_until_drained();

      // full store while the response side holds off
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      run_fill_drain(1'b1);
      wait_until_drained();

      // random phases of mixed requests
      phase = 0;
      while (request_count < ITEM_TARGET) begin
         req_idle_on = (phase % 4) != 1;
         rsp_idle_on = (phase % 4) != 2;
         foreach (value_pool[i]) value_pool[i] = $urandom;
         if (phase == 3) begin
            run_fill_drain(1'b0);
         end else begin
            len = $urandom_range(30, 60);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 99);
               if (r < 35) add_request(ACT_PUSH, pick_value(70));
               else if (r < 70) add_request(ACT_POP, $urandom);
               else if (r < 90) add_request(ACT_SEARCH, pick_value(60));
               else add_request(ACT_DUMP, $urandom);
            end
         end
         wait_until_drained();
         phase++;
      end

      wait_until_drained();
      repeat (DEPTH + 10) @(posedge clock);
      if (error_count == 0 && owed_responses.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #(40_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/lws_pkg.sv
src/lws_ifs.sv
src/lws_front.sv
src/lws_back.sv
src/lifo_store_with_search.sv
test/tb_lifo_store_with_search.sv
